>>> design/spin_one_metropolis_update_assert.svh
// Assertion macros for the spin-1 update block
`ifndef SPIN_ONE_METROPOLIS_UPDATE_ASSERT_SVH
`define SPIN_ONE_METROPOLIS_UPDATE_ASSERT_SVH

`define SOM_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");

`define SOM_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> design/som_pkg.sv
package som_pkg;
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] CFG_BETA = 2'd0;
    localparam logic [1:0] CFG_K    = 2'd1;
    localparam logic [1:0] CFG_DELTA = 2'd2;

    localparam int TOTAL_W = 18;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 18'sh1FFFF;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 18'sh20000;

    typedef struct packed {
        logic       start;
        logic [6:0] exp;
    } pow_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] result;
    } pow_rsp_t;
endpackage

>>> design/spin_one_metropolis_update.sv
// Metropolis update of one spin-1 site (Blume-Emery-Griffiths model).
// Command channel: an item is taken at a clock edge with start high and
// busy low. func selects a spin write, an energy total load, an update or a no-op.
// An update reads the six neighbors and then the site from the site memory,
// one read a cycle, computes dE, and for dE > 0 raises beta to dE by
// square-and-multiply on one shared 17x17 multiplier. Accepted moves write
// the spin back and add dE to the saturating energy total.
// Result: done pulses for one cycle with new_spin, accepted, energy_delta
// and energy_total; the receiver cannot stall it.
// busy drops in the done cycle, so a new item is taken only after the last is done.
// Configuration: cfg_we, cfg_index, cfg_data, written while idle; the block does not enforce this.
// Reset clears the control and the energy total and sets the configuration
// to its defaults; the site memory is undefined until written.
module spin_one_metropolis_update
    import som_pkg::*;
#(
    parameter int MAX_SITES = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [9:0]         site,
    input  logic signed [17:0] value,
    input  logic               pick,
    input  logic [5:0]         neighbor_mask,
    input  logic [9:0]         neighbor_0,
    input  logic [9:0]         neighbor_1,
    input  logic [9:0]         neighbor_2,
    input  logic [9:0]         neighbor_3,
    input  logic [9:0]         neighbor_4,
    input  logic [9:0]         neighbor_5,
    input  logic [15:0]        accept_random,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [1:0]  new_spin,
    output logic               accepted,
    output logic signed [7:0]  energy_delta,
    output logic signed [17:0] energy_total
);
    `include "spin_one_metropolis_update_assert.svh"

    localparam int AW = $clog2(MAX_SITES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_CALC = 7'b0000100,
        S_POW  = 7'b0001000,
        S_WAIT = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0] mem [MAX_SITES];
    logic [AW-1:0] raddr;
    logic [1:0]    rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [1:0]    wdata;

    logic [15:0]       beta_reg;
    logic signed [4:0] k_reg, delta_reg;
    logic signed [17:0] total_reg, total_next;

    logic [1:0]  func_reg;
    logic [AW-1:0] site_reg;
    logic signed [17:0] value_reg;
    logic        pick_reg;
    logic [5:0]  mask_reg;
    logic [AW-1:0] nb_reg [6];
    logic [15:0] rnd_reg;

    logic [2:0]  cnt_reg, cnt_next;
    logic signed [1:0] old_reg, old_next;
    logic signed [1:0] nbv_reg [6];
    logic signed [1:0] news_reg, news_next;
    logic signed [7:0] de_reg, de_next;
    logic        acc_reg, acc_next;
    logic        done_reg, done_next;
    logic signed [1:0] out_spin_reg, out_spin_next;

    pow_req_t preq;
    pow_rsp_t prsp;

    som_beta_pow u_pow (
        .clk(clk), .rst_n(rst_n), .beta(beta_reg), .req(preq), .rsp(prsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= 16'd32768;
            k_reg <= '0;
            delta_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BETA:  beta_reg <= cfg_data;
                CFG_K:     k_reg <= cfg_data[4:0];
                CFG_DELTA: delta_reg <= cfg_data[4:0];
                default:   ;
            endcase
        end
    end

    // read addresses: neighbors first, then the site itself
    always_comb
    begin
        if (cnt_reg < 3'd6)
            raddr = nb_reg[cnt_reg];
        else
            raddr = site_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // energy change: pair and biquadratic terms over the masked neighbors, plus the delta term
    logic signed [9:0] de_calc;
    logic signed [9:0] sum_lin, sum_sq_new, sum_sq_old;
    logic signed [2:0] ds;
    logic signed [2:0] dsq;
    always_comb
    begin
        sum_lin = '0;
        sum_sq_new = '0;
        sum_sq_old = '0;
        for (int k = 0; k < 6; k++)
        begin
            if (mask_reg[k])
            begin
                sum_lin = sum_lin + 10'(nbv_reg[k]);
                sum_sq_new = sum_sq_new + ((news_reg != 0 && nbv_reg[k] != 0) ? 10'sd1 : 10'sd0);
                sum_sq_old = sum_sq_old + ((old_reg != 0 && nbv_reg[k] != 0) ? 10'sd1 : 10'sd0);
            end
        end
        ds = 3'(news_reg) - 3'(old_reg);
        dsq = 3'((news_reg != 0) ? 1 : 0) - 3'((old_reg != 0) ? 1 : 0);
        de_calc = 10'(ds) * sum_lin + 10'(k_reg) * (sum_sq_new - sum_sq_old)
                  - 10'(delta_reg) * 10'(dsq);
    end

    logic signed [18:0] tsum;
    assign tsum = 19'(total_reg) + 19'(de_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        old_next = old_reg;
        news_next = news_reg;
        de_next = de_reg;
        acc_next = acc_reg;
        done_next = 1'b0;
        out_spin_next = out_spin_reg;
        total_next = total_reg;
        we = 1'b0;
        waddr = site_reg;
        wdata = news_reg;
        preq.start = 1'b0;
        preq.exp = de_reg[6:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    if (func == FUNC_UPDATE)
                        state_next = S_READ;
                    else
                        state_next = S_OUT;
                end
            end
            S_READ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    old_next = rdata_reg;
                    unique case (rdata_reg)
                        2'b11:   news_next = pick_reg ? 2'sd1 : 2'sd0;
                        2'b00:   news_next = pick_reg ? 2'sd1 : -2'sd1;
                        default: news_next = pick_reg ? 2'sd0 : -2'sd1;
                    endcase
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                de_next = de_calc[7:0];
                state_next = S_POW;
            end
            S_POW:
            begin
                if (de_reg <= 0)
                begin
                    acc_next = 1'b1;
                    state_next = S_DEC;
                end
                else
                begin
                    preq.start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (prsp.done)
                begin
                    acc_next = {1'b0, rnd_reg} <= prsp.result;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (acc_reg)
                begin
                    we = 1'b1;
                    out_spin_next = news_reg;
                    if (tsum > 19'(TOTAL_MAX))
                        total_next = TOTAL_MAX;
                    else if (tsum < 19'(TOTAL_MIN))
                        total_next = TOTAL_MIN;
                    else
                        total_next = tsum[17:0];
                end
                else
                    out_spin_next = old_reg;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                de_next = '0;
                if (func_reg == FUNC_WRITE)
                begin
                    we = 1'b1;
                    wdata = (value_reg > 1) ? 2'sd1 : ((value_reg < -1) ? -2'sd1 : value_reg[1:0]);
                    out_spin_next = wdata;
                    acc_next = 1'b1;
                end
                else if (func_reg == FUNC_LOAD)
                begin
                    total_next = value_reg;
                    out_spin_next = '0;
                    acc_next = 1'b1;
                end
                else
                begin
                    out_spin_next = '0;
                    acc_next = 1'b0;
                end
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            total_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            total_reg <= total_next;
            cnt_reg <= cnt_next;
        end
    end

    // read data for neighbor k arrives in the cycle after its address
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ && cnt_reg != 3'd0 && cnt_reg != 3'd7)
            nbv_reg[cnt_reg - 3'd1] <= rdata_reg;
        old_reg <= old_next;
        news_reg <= news_next;
        de_reg <= de_next;
        acc_reg <= acc_next;
        out_spin_reg <= out_spin_next;
        if (start && state_reg == S_IDLE)
        begin
            func_reg <= func;
            site_reg <= AW'(site);
            value_reg <= value;
            pick_reg <= pick;
            mask_reg <= neighbor_mask;
            nb_reg[0] <= AW'(neighbor_0);
            nb_reg[1] <= AW'(neighbor_1);
            nb_reg[2] <= AW'(neighbor_2);
            nb_reg[3] <= AW'(neighbor_3);
            nb_reg[4] <= AW'(neighbor_4);
            nb_reg[5] <= AW'(neighbor_5);
            rnd_reg <= accept_random;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign new_spin = out_spin_reg;
    assign accepted = acc_reg;
    assign energy_delta = de_reg;
    assign energy_total = total_reg;

    `SOM_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `SOM_ASSERT_IMP(a_neg_acc, clk, rst_n, done && energy_delta <= 0 && func_reg == FUNC_UPDATE,
        accepted)
    `SOM_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule

>>> design/som_beta_pow.sv
module som_beta_pow
    import som_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] beta,
    input  pow_req_t    req,
    output pow_rsp_t    rsp
);
    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_MULP = 3'b010,
        P_MULB = 3'b100
    } pstate_t;

    pstate_t     state_reg, state_next;
    logic [16:0] p_reg, p_next;
    logic [16:0] b_reg, b_next;
    logic [6:0]  e_reg, e_next;
    logic        done_reg, done_next;
    logic [33:0] prod;

    // one multiplier shared by both steps of an exponent bit
    always_comb
    begin
        if (state_reg == P_MULP)
            prod = 34'(p_reg) * 34'(b_reg);
        else
            prod = 34'(b_reg) * 34'(b_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        p_next = p_reg;
        b_next = b_reg;
        e_next = e_reg;
        done_next = 1'b0;
        unique case (state_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    p_next = 17'h10000;
                    b_next = {1'b0, beta};
                    e_next = req.exp;
                    state_next = P_MULP;
                end
            end
            P_MULP:
            begin
                if (e_reg == '0)
                begin
                    done_next = 1'b1;
                    state_next = P_IDLE;
                end
                else
                begin
                    if (e_reg[0])
                        p_next = prod[32:16];
                    state_next = P_MULB;
                end
            end
            P_MULB:
            begin
                b_next = prod[32:16];
                e_next = e_reg >> 1;
                state_next = P_MULP;
            end
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        b_reg <= b_next;
        e_reg <= e_next;
    end

    assign rsp.done = done_reg;
    assign rsp.result = p_reg;
endmodule

>>> test/spin_one_metropolis_update_checker.sv
`timescale 1ns / 1ps

module spin_one_metropolis_update_checker
    import som_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         func,
    input  logic [9:0]         site,
    input  logic signed [17:0] value,
    input  logic               pick,
    input  logic [5:0]         neighbor_mask,
    input  logic [9:0]         neighbor_0,
    input  logic [9:0]         neighbor_1,
    input  logic [9:0]         neighbor_2,
    input  logic [9:0]         neighbor_3,
    input  logic [9:0]         neighbor_4,
    input  logic [9:0]         neighbor_5,
    input  logic [15:0]        accept_random,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               done,
    input  logic signed [1:0]  new_spin,
    input  logic               accepted,
    input  logic signed [7:0]  energy_delta,
    input  logic signed [17:0] energy_total,
    output int                 failures,
    output int                 pending
);
    typedef struct packed {
        logic signed [1:0]  spin;
        logic               acc;
        logic signed [7:0]  de;
        logic signed [17:0] total;
    } outcome_t;

    logic signed [1:0] spins [1024];
    logic [15:0]       beta;
    int                coupling_k;
    int                field_d;
    int                total;
    outcome_t          expected_q [$];

    function automatic int beta_power(input logic [15:0] b0, input int e);
        longint p;
        longint b;
        p = 65536;
        b = b0;
        while (e != 0)
        begin
            if (e & 1)
                p = (p * b) >>> 16;
            b = (b * b) >>> 16;
            e = e >> 1;
        end
        return int'(p);
    endfunction

    function automatic int site_energy(input int s, input int nb [6], input logic [5:0] m,
                                       input int k, input int d);
        int e;
        int q;
        e = 0;
        for (int i = 0; i < 6; i++)
            if (m[i])
            begin
                q = s * nb[i];
                e += q + k * q * q;
            end
        return e - d * s * s;
    endfunction

    function automatic outcome_t predict_transfer();
        outcome_t o;
        int       nb [6];
        int       olds;
        int       news;
        int       de;
        int       t;
        logic     acc;
        o = '0;
        case (func)
            FUNC_WRITE:
            begin
                news = (value > 1) ? 1 : ((value < -1) ? -1 : int'(value));
                spins[site] = news[1:0];
                o.spin = news[1:0];
                o.acc = 1'b1;
            end
            FUNC_LOAD:
            begin
                total = int'(value);
                o.acc = 1'b1;
            end
            FUNC_UPDATE:
            begin
                nb[0] = spins[neighbor_0];
                nb[1] = spins[neighbor_1];
                nb[2] = spins[neighbor_2];
                nb[3] = spins[neighbor_3];
                nb[4] = spins[neighbor_4];
                nb[5] = spins[neighbor_5];
                olds = spins[site];
                if (olds < 0)
                    news = pick ? 1 : 0;
                else if (olds == 0)
                    news = pick ? 1 : -1;
                else
                    news = pick ? 0 : -1;
                de = site_energy(news, nb, neighbor_mask, coupling_k, field_d)
                   - site_energy(olds, nb, neighbor_mask, coupling_k, field_d);
                acc = (de <= 0) || (int'(accept_random) <= beta_power(beta, de));
                if (acc)
                begin
                    t = total + de;
                    spins[site] = news[1:0];
                    total = (t > 131071) ? 131071 : ((t < -131072) ? -131072 : t);
                end
                o.spin = acc ? news[1:0] : olds[1:0];
                o.acc = acc;
                o.de = de[7:0];
            end
            default:
            begin
            end
        endcase
        o.total = total[17:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
        begin
            beta <= 16'd32768;
            coupling_k <= 0;
            field_d <= 0;
            total = 0;
            failures = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BETA)
                    beta <= cfg_data;
                else if (cfg_index == CFG_K)
                    coupling_k <= int'($signed(cfg_data[4:0]));
                else if (cfg_index == CFG_DELTA)
                    field_d <= int'($signed(cfg_data[4:0]));
            end
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: spin %0d acc %0d de %0d tot %0d",
                             $time, new_spin, accepted, energy_delta, energy_total);
                    failures++;
                end
                else
                begin
                    exp_o = expected_q.pop_front();
                    if (new_spin !== exp_o.spin)
                    begin
                        $display("%0t: new_spin expected %0d actual %0d",
                                 $time, exp_o.spin, new_spin);
                        failures++;
                    end
                    if (accepted !== exp_o.acc)
                    begin
                        $display("%0t: accepted expected %0d actual %0d",
                                 $time, exp_o.acc, accepted);
                        failures++;
                    end
                    if (energy_delta !== exp_o.de)
                    begin
                        $display("%0t: energy_delta expected %0d actual %0d",
                                 $time, exp_o.de, energy_delta);
                        failures++;
                    end
                    if (energy_total !== exp_o.total)
                    begin
                        $display("%0t: energy_total expected %0d actual %0d",
                                 $time, exp_o.total, energy_total);
                        failures++;
                    end
                end
            end
            // predict after the result check so a same-edge transfer queues behind
            if (start && !busy)
                expected_q.push_back(predict_transfer());
        end
        pending = expected_q.size();
    end
endmodule

>>> test/tb_spin_one_metropolis_update.sv
`timescale 1ns / 1ps

module tb_spin_one_metropolis_update;
    import som_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES = 7;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         func;
    logic [9:0]         site;
    logic signed [17:0] value;
    logic               pick;
    logic [5:0]         neighbor_mask;
    logic [9:0]         nbr [6];
    logic [15:0]        accept_random;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               done;
    logic signed [1:0]  new_spin;
    logic               accepted;
    logic signed [7:0]  energy_delta;
    logic signed [17:0] energy_total;
    int                 failures;
    int                 pending;
    int                 cycles;
    int                 written_sites [$];
    bit                 is_written [1024];

    spin_one_metropolis_update DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func), .site(site),
        .value(value), .pick(pick), .neighbor_mask(neighbor_mask),
        .neighbor_0(nbr[0]), .neighbor_1(nbr[1]), .neighbor_2(nbr[2]),
        .neighbor_3(nbr[3]), .neighbor_4(nbr[4]), .neighbor_5(nbr[5]),
        .accept_random(accept_random), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .new_spin(new_spin), .accepted(accepted),
        .energy_delta(energy_delta), .energy_total(energy_total)
    );

    spin_one_metropolis_update_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func), .site(site),
        .value(value), .pick(pick), .neighbor_mask(neighbor_mask),
        .neighbor_0(nbr[0]), .neighbor_1(nbr[1]), .neighbor_2(nbr[2]),
        .neighbor_3(nbr[3]), .neighbor_4(nbr[4]), .neighbor_5(nbr[5]),
        .accept_random(accept_random), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .new_spin(new_spin), .accepted(accepted),
        .energy_delta(energy_delta), .energy_total(energy_total),
        .failures(failures), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // drive one transfer; it is taken at the rising edge after busy is seen low
    task automatic send(input logic [1:0] f, input int s, input int v, input bit p,
                        input logic [5:0] m, input int n [6], input int r);
        @(negedge clk);
        while (busy)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        func <= f;
        site <= s[9:0];
        value <= v[17:0];
        pick <= p;
        neighbor_mask <= m;
        for (int i = 0; i < 6; i++)
            nbr[i] <= n[i][9:0];
        accept_random <= r[15:0];
        if (f == FUNC_WRITE && !is_written[s[9:0]])
        begin
            is_written[s[9:0]] = 1'b1;
            written_sites.push_back(s[9:0]);
        end
        @(posedge clk);
    endtask

    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        start <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
    endtask

    function automatic int any_written();
        return written_sites[$urandom_range(written_sites.size() - 1)];
    endfunction

    task automatic random_update();
        int n [6];
        int s;
        int r;
        s = any_written();
        for (int i = 0; i < 6; i++)
            n[i] = ($urandom_range(9) == 0) ? s : any_written();
        case ($urandom_range(9))
            0: r = 0;
            1: r = 65535;
            default: r = $urandom_range(65535);
        endcase
        send(FUNC_UPDATE, s, $urandom, $urandom_range(1), $urandom_range(63), n, r);
    endtask

    task automatic random_item();
        int n [6];
        int sel;
        int v;
        for (int i = 0; i < 6; i++)
            n[i] = $urandom_range(1023);
        sel = $urandom_range(99);
        if (sel < 14)
        begin
            v = ($urandom_range(4) == 0) ? int'($urandom) : int'($urandom_range(2)) - 1;
            send(FUNC_WRITE, $urandom_range(1023), v, $urandom_range(1),
                 $urandom_range(63), n, $urandom_range(65535));
        end
        else if (sel < 18)
        begin
            case ($urandom_range(3))
                0: v = 131071 - $urandom_range(40);
                1: v = -131072 + $urandom_range(40);
                default: v = $urandom;
            endcase
            send(FUNC_LOAD, $urandom_range(1023), v, $urandom_range(1),
                 $urandom_range(63), n, $urandom_range(65535));
        end
        else if (sel < 20)
            send(FUNC_UNUSED, $urandom_range(1023), $urandom, $urandom_range(1),
                 $urandom_range(63), n, $urandom_range(65535));
        else
            random_update();
    endtask

    logic [15:0] phase_beta [PHASES] = '{16'd65535, 16'd0, 16'd60000, 16'd50000,
                                         16'd65535, 16'd40000, 16'd30000};
    int phase_k [PHASES] = '{15, -16, 8, -8, 1, 3, -1};
    int phase_d [PHASES] = '{-16, 15, -8, 8, -2, 2, 0};

    initial
    begin
        int n [6];
        int burst;
        int count;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_WRITE;
        site = '0;
        value = '0;
        pick = 1'b0;
        neighbor_mask = '0;
        for (int i = 0; i < 6; i++)
            nbr[i] = '0;
        accept_random = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_BETA;
        cfg_data = '0;
        cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, clamping, self neighbor, saturation, unused func
        n = '{0, 0, 0, 0, 0, 0};
        send(FUNC_WRITE, 0, 1, 0, 0, n, 0);
        send(FUNC_WRITE, 1023, -1, 1, 63, n, 65535);
        send(FUNC_WRITE, 5, 131071, 0, 0, n, 0);
        send(FUNC_WRITE, 6, -131072, 0, 0, n, 0);
        send(FUNC_WRITE, 7, 0, 0, 0, n, 0);
        send(FUNC_WRITE, 682, 3, 0, 0, n, 0);
        send(FUNC_WRITE, 341, -2, 0, 0, n, 0);
        n = '{1023, 5, 6, 7, 0, 1023};
        send(FUNC_UPDATE, 0, 0, 0, 63, n, 0);
        send(FUNC_UPDATE, 0, -1, 1, 63, n, 65535);
        n = '{341, 682, 1023, 0, 7, 7};
        send(FUNC_UPDATE, 7, 131071, 1, 42, n, 32768);
        send(FUNC_UPDATE, 1023, 0, 0, 21, n, 1);
        send(FUNC_LOAD, 0, 131071, 0, 0, n, 0);
        send(FUNC_UPDATE, 5, 0, 0, 63, n, 0);
        send(FUNC_UPDATE, 5, 0, 1, 63, n, 0);
        send(FUNC_LOAD, 1023, -131072, 1, 63, n, 65535);
        send(FUNC_UPDATE, 6, 0, 0, 63, n, 0);
        send(FUNC_UPDATE, 6, 0, 1, 0, n, 65535);
        send(FUNC_UNUSED, 1023, -1, 1, 63, n, 65535);
        send(FUNC_LOAD, 0, 0, 0, 0, n, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // hold until the block has drained before touching the registers
            idle(1);
            while (pending != 0)
                idle(1);
            idle(30);
            write_reg(CFG_BETA, phase_beta[ph]);
            write_reg(CFG_K, {11'b0, phase_k[ph][4:0]});
            write_reg(CFG_DELTA, {11'b0, phase_d[ph][4:0]});
            @(negedge clk);
            cfg_we <= 1'b0;
            count = 0;
            while (count < RANDOM_ITEMS / PHASES)
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++)
                    random_item();
                count += burst;
                if ($urandom_range(1))
                    idle($urandom_range(1, 15));
            end
        end

        idle(1);
        while (pending != 0)
            idle(1);
        idle(30);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/som_pkg.sv
design/som_beta_pow.sv
design/spin_one_metropolis_update.sv
test/spin_one_metropolis_update_checker.sv
test/tb_spin_one_metropolis_update.sv
